FILE: hw/rtl/pal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types, widths and constants for the polyline arc length block.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SUM_W     = 48;
    localparam int SCALE_W   = 32;
    localparam int BULGE_W   = 24;
    localparam int ROOT_W    = 34;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int SREM_W    = ROOT_W + 2;
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = 82;
    localparam int HALF_W    = 24;
    localparam int CORD_W    = 41;
    localparam int ANG_W     = 33;
    localparam int AVAL_W    = 32;
    localparam int QUO_W     = 48;
    localparam int STEP_W    = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW   = 2;
    localparam int FIFO_CW   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BULGE      = 1'd1;

    localparam logic [SCALE_W-1:0] UNIT_SCALE_RESET = 32'd65536;
    localparam logic [SUM_W-1:0]   SUM_MAX          = {SUM_W{1'b1}};

    localparam logic [STEP_W-1:0] SQRT_LAST   = 6'd33;
    localparam logic [STEP_W-1:0] CORDIC_LAST = 6'd30;
    localparam logic [STEP_W-1:0] DIV_LAST    = 6'd47;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      last_point;
    } pal_in_t;

    typedef struct packed {
        logic [SUM_W-1:0] length_m;
        logic             used_arc;
        logic             overflowed;
    } pal_out_t;

    // one classified point handed from front to back
    typedef struct packed {
        logic [DIFF_W-1:0] dx;
        logic [DIFF_W-1:0] dy;
        logic [DIFF_W-1:0] dz;
        logic              has_seg;
        logic              last_point;
        logic              two_points;
    } pal_entry_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_SQZ, S_SQADD, S_SQRT, S_ACCUM,
        S_CORDIC, S_DIV, S_MAU, S_FSUM, S_AM0, S_AM1, S_AM2, S_ASAT,
        S_SM0, S_SM1, S_SM2, S_SSAT, S_EMIT
    } pal_state_t;

    // atan(2^-i) in Q.30 radians
    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
        logic [ANG_W-1:0] one;
        one = ANG_W'(1);
        unique case (i)
            5'd0:    atan_q30 = 33'sd843314857;
            5'd1:    atan_q30 = 33'sd497837829;
            5'd2:    atan_q30 = 33'sd263043837;
            5'd3:    atan_q30 = 33'sd133525159;
            5'd4:    atan_q30 = 33'sd67021688;
            5'd5:    atan_q30 = 33'sd33543515;
            5'd6:    atan_q30 = 33'sd16775850;
            5'd7:    atan_q30 = 33'sd8388437;
            5'd8:    atan_q30 = 33'sd4194283;
            5'd9:    atan_q30 = 33'sd2097149;
            5'd10:   atan_q30 = 33'sd1048576;
            default: atan_q30 = $signed(one << (5'd30 - i));
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/pal_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_front
// Accepts points, keeps the previous point and the point count, and queues
// absolute coordinate deltas with path flags for the back end.
// ----------------------------------------------------------------------------
module pal_front
    import pal_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire pal_in_t    in_data,
    input  wire logic       fifo_full,
    output logic            in_stall,
    output logic            push,
    output pal_entry_t      entry
);

    logic [COORD_W-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic [1:0]         count_reg, count_next;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic [DIFF_W-1:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        abs_diff = d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
    endfunction

    assign in_stall = fifo_full;
    assign push     = in_valid & ~fifo_full;

    always_comb
    begin
        entry.dx         = abs_diff(in_data.pos_x, prev_x_reg);
        entry.dy         = abs_diff(in_data.pos_y, prev_y_reg);
        entry.dz         = abs_diff(in_data.pos_z, prev_z_reg);
        entry.has_seg    = (count_reg != 2'd0);
        entry.last_point = in_data.last_point;
        entry.two_points = (count_reg == 2'd1);
        if (in_data.last_point)
        begin
            count_next = 2'd0;
        end
        else if (count_reg == 2'd3)
        begin
            count_next = count_reg;
        end
        else
        begin
            count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_z_reg <= '0;
        end
        else if (push)
        begin
            count_reg  <= count_next;
            prev_x_reg <= in_data.pos_x;
            prev_y_reg <= in_data.pos_y;
            prev_z_reg <= in_data.pos_z;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/pal_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_queue
// Short FIFO of classified points between front and back.
// ----------------------------------------------------------------------------
module pal_queue
    import pal_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire pal_entry_t wr_entry,
    output logic            full,
    input  wire logic       pop,
    output logic            empty,
    output pal_entry_t      head
);

    pal_entry_t           slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;

    assign full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + FIFO_CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - FIFO_CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/pal_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_back
// Sequenced datapath: squares on a shared multiplier, bit-serial square
// root, saturating sum, CORDIC arctangent, restoring divider, arc and unit
// scaling in partial products, and the output register.
// ----------------------------------------------------------------------------
module pal_back
    import pal_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               empty,
    input  wire pal_entry_t         head,
    output logic                    pop,
    input  wire logic [SCALE_W-1:0] unit_scale,
    input  wire logic [BULGE_W-1:0] bulge_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output pal_out_t                out_data
);

    pal_state_t state_reg, state_next;

    logic [DIFF_W-1:0]        dx_reg, dy_reg, dz_reg;
    logic [DIFF_W-1:0]        dx_next, dy_next, dz_next;
    logic                     last_reg, last_next, two_reg, two_next;
    logic [PROD_W-1:0]        prod_reg;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [RAD_W-1:0]         rad_reg, rad_next;
    logic [SREM_W-1:0]        srem_reg, srem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic [STEP_W-1:0]        cnt_reg, cnt_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic                     sat_reg, sat_next;
    logic [SUM_W-1:0]         len_reg, len_next;
    logic                     ovf_reg, ovf_next, arc_reg, arc_next;
    logic signed [CORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ANG_W-1:0]  cz_reg, cz_next;
    logic [BULGE_W-1:0]       u_reg, u_next;
    logic [AVAL_W-1:0]        a_reg, a_next;
    logic [QUO_W-1:0]         quo_reg, quo_next, f_reg, f_next;
    logic [BULGE_W-1:0]       rem_reg, rem_next;
    pal_out_t                 out_reg;
    logic                     out_valid_reg, out_load;

    // step temporaries
    logic [SREM_W+1:0]        sq_rem, sq_trial;
    logic [SUM_W:0]           sum_wide;
    logic signed [CORD_W-1:0] xs, ys;
    logic signed [ANG_W-1:0]  ang;
    logic [BULGE_W:0]         dv_rem;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        dx_next = dx_reg;   dy_next = dy_reg;   dz_next = dz_reg;
        last_next = last_reg;   two_next = two_reg;
        acc_next = acc_reg;   rad_next = rad_reg;
        srem_next = srem_reg;   root_next = root_reg;
        cnt_next = cnt_reg;
        sum_next = sum_reg;   sat_next = sat_reg;
        len_next = len_reg;   ovf_next = ovf_reg;   arc_next = arc_reg;
        cx_next = cx_reg;   cy_next = cy_reg;   cz_next = cz_reg;
        u_next = u_reg;   a_next = a_reg;
        quo_next = quo_reg;   f_next = f_reg;   rem_next = rem_reg;
        mul_a = '0;
        mul_b = '0;
        pop = 1'b0;
        out_load = 1'b0;

        sq_rem   = {srem_reg, rad_reg[RAD_W-1 -: 2]};
        sq_trial = {2'b00, root_reg, 2'b01};
        sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(root_reg);
        xs       = cx_reg >>> cnt_reg;
        ys       = cy_reg >>> cnt_reg;
        ang      = atan_q30(cnt_reg[4:0]);
        dv_rem   = {rem_reg, quo_reg[QUO_W-1]};

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    dx_next   = head.dx;
                    dy_next   = head.dy;
                    dz_next   = head.dz;
                    last_next = head.last_point;
                    two_next  = head.two_points;
                    if (head.has_seg)
                    begin
                        state_next = S_SQX;
                    end
                    else if (head.last_point)
                    begin
                        len_next   = sum_reg;
                        ovf_next   = sat_reg;
                        arc_next   = 1'b0;
                        sum_next   = '0;
                        sat_next   = 1'b0;
                        state_next = S_SM0;
                    end
                end
            end
            S_SQX:
            begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'(dx_reg);
                state_next = S_SQY;
            end
            S_SQY:
            begin
                mul_a = MUL_W'(dy_reg);
                mul_b = MUL_W'(dy_reg);
                acc_next = ACC_W'(prod_reg);
                state_next = S_SQZ;
            end
            S_SQZ:
            begin
                mul_a = MUL_W'(dz_reg);
                mul_b = MUL_W'(dz_reg);
                acc_next = acc_reg + ACC_W'(prod_reg);
                state_next = S_SQADD;
            end
            S_SQADD:
            begin
                rad_next   = RAD_W'(acc_reg + ACC_W'(prod_reg));
                srem_next  = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                // two radicand bits per step, one root bit out
                if (sq_rem >= sq_trial)
                begin
                    srem_next = SREM_W'(sq_rem - sq_trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = SREM_W'(sq_rem);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next = {rad_reg[RAD_W-3:0], 2'b00};
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                if (sum_wide[SUM_W])
                begin
                    sum_next = SUM_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    sum_next = sum_wide[SUM_W-1:0];
                end
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    len_next = sum_next;
                    ovf_next = sat_next;
                    arc_next = 1'b0;
                    sum_next = '0;
                    sat_next = 1'b0;
                    if (two_reg && (|bulge_value))
                    begin
                        u_next     = bulge_value[BULGE_W-1] ? (~bulge_value + BULGE_W'(1))
                                                            : bulge_value;
                        cx_next    = $signed(CORD_W'(64'd1 << 30));
                        cy_next    = $signed({3'b000, u_next, 14'b0});
                        cz_next    = '0;
                        cnt_next   = '0;
                        state_next = S_CORDIC;
                    end
                    else
                    begin
                        state_next = S_SM0;
                    end
                end
            end
            S_CORDIC:
            begin
                if (!cy_reg[CORD_W-1] && (cy_reg != '0))
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + ang;
                end
                else
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - ang;
                end
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == CORDIC_LAST)
                begin
                    a_next     = cz_next[ANG_W-1] ? '0 : cz_next[AVAL_W-1:0];
                    quo_next   = {a_next, 16'b0};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (dv_rem >= {1'b0, u_reg})
                begin
                    rem_next = BULGE_W'(dv_rem - {1'b0, u_reg});
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = dv_rem[BULGE_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_MAU;
                end
            end
            S_MAU:
            begin
                mul_a = MUL_W'(a_reg);
                mul_b = MUL_W'(u_reg);
                state_next = S_FSUM;
            end
            S_FSUM:
            begin
                f_next = quo_reg + QUO_W'(prod_reg[PROD_W-1:16]);
                state_next = S_AM0;
            end
            S_AM0:
            begin
                mul_a = MUL_W'(root_reg);
                mul_b = MUL_W'(f_reg[HALF_W-1:0]);
                state_next = S_AM1;
            end
            S_AM1:
            begin
                mul_a = MUL_W'(root_reg);
                mul_b = MUL_W'(f_reg[QUO_W-1:HALF_W]);
                acc_next = ACC_W'(prod_reg);
                state_next = S_AM2;
            end
            S_AM2:
            begin
                acc_next = acc_reg + (ACC_W'(prod_reg) << HALF_W);
                state_next = S_ASAT;
            end
            S_ASAT:
            begin
                arc_next = 1'b1;
                if (|acc_reg[ACC_W-1:SUM_W+30])
                begin
                    len_next = SUM_MAX;
                    ovf_next = 1'b1;
                end
                else
                begin
                    len_next = acc_reg[SUM_W+29:30];
                end
                state_next = S_SM0;
            end
            S_SM0:
            begin
                mul_a = MUL_W'(len_reg[HALF_W-1:0]);
                mul_b = MUL_W'(unit_scale);
                state_next = S_SM1;
            end
            S_SM1:
            begin
                mul_a = MUL_W'(len_reg[SUM_W-1:HALF_W]);
                mul_b = MUL_W'(unit_scale);
                acc_next = ACC_W'(prod_reg);
                state_next = S_SM2;
            end
            S_SM2:
            begin
                acc_next = acc_reg + (ACC_W'(prod_reg) << HALF_W);
                state_next = S_SSAT;
            end
            S_SSAT:
            begin
                if (|acc_reg[ACC_W-1:SUM_W+16])
                begin
                    len_next = SUM_MAX;
                    ovf_next = 1'b1;
                end
                else
                begin
                    len_next = acc_reg[SUM_W+15:16];
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            sat_reg       <= sat_next;
            out_valid_reg <= (out_valid_reg & out_stall) | out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dz_reg   <= dz_next;
        last_reg <= last_next;
        two_reg  <= two_next;
        acc_reg  <= acc_next;
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        len_reg  <= len_next;
        ovf_reg  <= ovf_next;
        arc_reg  <= arc_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        u_reg    <= u_next;
        a_reg    <= a_next;
        quo_reg  <= quo_next;
        f_reg    <= f_next;
        rem_reg  <= rem_next;
        if (out_load)
        begin
            out_reg.length_m   <= len_reg;
            out_reg.used_arc   <= arc_reg;
            out_reg.overflowed <= ovf_reg;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/polyline_arc_length.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_arc_length
// Length of a 3D polyline streamed as points, with a two-point bulge arc.
// ----------------------------------------------------------------------------
// Points enter a four-deep queue at one per cycle until it fills; the back
// end then works one point at a time. A point that closes a segment runs
// the 34-step bit-serial square root after three squares on the shared
// multiplier. The last point of a path adds unit scaling and output load;
// a two-point path with a nonzero bulge adds the 31-step CORDIC arctangent
// and the 48-step divider. One transaction comes out per path, on its last
// point, held in an output register so the queue keeps filling while it
// waits.
module polyline_arc_length
    import pal_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire pal_in_t              in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output pal_out_t                  out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [SCALE_W-1:0] unit_scale_reg;
    logic [BULGE_W-1:0] bulge_value_reg;
    logic               fifo_full, fifo_empty, push, pop;
    pal_entry_t         wr_entry, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_scale_reg  <= UNIT_SCALE_RESET;
            bulge_value_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UNIT_SCALE: unit_scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_BULGE:      bulge_value_reg <= cfg_data[BULGE_W-1:0];
                default:        ;
            endcase
        end
    end

    pal_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .fifo_full (fifo_full),
        .in_stall  (in_stall),
        .push      (push),
        .entry     (wr_entry)
    );

    pal_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (fifo_full),
        .pop      (pop),
        .empty    (fifo_empty),
        .head     (head)
    );

    pal_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (fifo_empty),
        .head        (head),
        .pop         (pop),
        .unit_scale  (unit_scale_reg),
        .bulge_value (bulge_value_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule
`default_nettype wire

FILE: bench/polyline_arc_length_tb.sv
// ----------------------------------------------------------------------------
// polyline_arc_length_tb
// Streams 3D point paths into the polyline length block, predicts each path
// length (segment sum or two-point bulge arc) and checks every result.
// ----------------------------------------------------------------------------
module polyline_arc_length_tb;
    import pal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DRAIN_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 3000000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    pal_in_t              in_data;
    logic                 out_valid;
    logic                 out_stall;
    pal_out_t             out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    polyline_arc_length u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // path tracker state
    logic [SCALE_W-1:0] scale_q;
    logic [BULGE_W-1:0] bulge_q;
    logic signed [COORD_W-1:0] last_x, last_y, last_z;
    int                 pts_seen;
    logic [SUM_W-1:0]   path_sum;
    logic               path_sat;

    pal_out_t path_len_q[$];
    int       errors;
    longint   cycles;
    bit       no_idle;
    int       out_hold;

    const longint atan_steps[11] = '{843314857, 497837829, 263043837, 133525159,
        67021688, 33543515, 16775850, 8388437, 4194283, 2097149, 1048576};

    function automatic longint abs_delta(logic signed [COORD_W-1:0] a,
                                         logic signed [COORD_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return (d < 0) ? -d : d;
    endfunction

    function automatic logic [63:0] root_floor(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] cc;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            cc = {64'd0, c} * {64'd0, c};
            if (cc <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic longint arctan_q30(longint u);
        longint x, y, z, a, xs, ys;
        x = longint'(1) << 30;
        y = u << 14;
        z = 0;
        for (int i = 0; i < 31; i++)
        begin
            a = (i < 11) ? atan_steps[i] : (longint'(1) << (30 - i));
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += a;
            end
            else
            begin
                x -= ys; y += xs; z -= a;
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    function automatic logic [SUM_W-1:0] clamp_sum(logic [127:0] v, inout logic sat);
        if (v > {80'd0, SUM_MAX})
        begin
            sat = 1'b1;
            return SUM_MAX;
        end
        return v[SUM_W-1:0];
    endfunction

    // advance the path tracker by one accepted point
    task automatic track_point(pal_in_t p);
        logic [63:0]  seg;
        logic [127:0] sq;
        logic [63:0]  dx, dy, dz, f, u, a;
        logic [SUM_W-1:0] len;
        logic         ovf;
        pal_out_t     r;
        seg = '0;
        if (pts_seen >= 1)
        begin
            dx = abs_delta(p.pos_x, last_x);
            dy = abs_delta(p.pos_y, last_y);
            dz = abs_delta(p.pos_z, last_z);
            sq = {64'd0, dx} * {64'd0, dx} + {64'd0, dy} * {64'd0, dy}
                 + {64'd0, dz} * {64'd0, dz};
            seg = root_floor(sq);
            if (seg > 64'(SUM_MAX - path_sum))
            begin
                path_sum = SUM_MAX;
                path_sat = 1'b1;
            end
            else
                path_sum = path_sum + seg[SUM_W-1:0];
        end
        if (pts_seen < 3)
            pts_seen++;
        last_x = p.pos_x;
        last_y = p.pos_y;
        last_z = p.pos_z;
        if (p.last_point)
        begin
            ovf = path_sat;
            len = path_sum;
            r.used_arc = 1'b0;
            if (pts_seen == 2 && bulge_q != '0)
            begin
                u = bulge_q[BULGE_W-1] ? (64'h1000000 - 64'(bulge_q)) : 64'(bulge_q);
                a = arctan_q30(u);
                f = ((a << 16) / u) + ((a * u) >> 16);
                len = clamp_sum(({64'd0, seg} * {64'd0, f}) >> 30, ovf);
                r.used_arc = 1'b1;
            end
            r.length_m = clamp_sum(({80'd0, len} * {96'd0, scale_q}) >> 16, ovf);
            r.overflowed = ovf;
            path_len_q.insert(path_len_q.size(), r);
            pts_seen = 0;
            path_sum = '0;
            path_sat = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one point; valid stays high across back-to-back transactions
    task automatic send_point(pal_in_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data = p;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_point(p);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (path_len_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        wait_idle();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_UNIT_SCALE)
            scale_q = val[SCALE_W-1:0];
        else
            bulge_q = val[BULGE_W-1:0];
    endtask

    function automatic pal_in_t make_point(logic signed [COORD_W-1:0] x,
        logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z, logic lst);
        pal_in_t p;
        p.pos_x = x;
        p.pos_y = y;
        p.pos_z = z;
        p.last_point = lst;
        return p;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(
        logic signed [COORD_W-1:0] near);
        if ($urandom_range(0, 1))
            return $urandom;
        return near + $signed(COORD_W'($urandom_range(0, 1 << 20))) - (1 << 19);
    endfunction

    task automatic test_single_point();
        send_point(make_point(32'sd0, 32'sd0, 32'sd0, 1'b1));
        send_point(make_point(32'h7fffffff, 32'h80000000, 32'sd5, 1'b1));
    endtask

    task automatic test_extreme_segments();
        write_reg(REG_UNIT_SCALE, 32'hffffffff);
        send_point(make_point(32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
        send_point(make_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0));
        send_point(make_point(32'h80000000, 32'h80000000, 32'h80000000, 1'b1));
        write_reg(REG_UNIT_SCALE, 32'd0);
        send_point(make_point(32'sd1, 32'sd2, 32'sd3, 1'b0));
        send_point(make_point(32'sd100, 32'sd200, 32'sd300, 1'b0));
        send_point(make_point(-32'sd7, 32'sd9, 32'sd0, 1'b1));
        write_reg(REG_UNIT_SCALE, UNIT_SCALE_RESET);
        send_point(make_point(32'sd0, 32'sd0, 32'sd0, 1'b0));
        send_point(make_point(32'sd3 << 12, 32'sd4 << 12, 32'sd0, 1'b0));
        send_point(make_point(32'sd3 << 12, 32'sd4 << 12, 32'sd12 << 12, 1'b1));
    endtask

    task automatic test_bulge_arc();
        logic [BULGE_W-1:0] bulges[5];
        bulges = '{24'd1, 24'hffffff, 24'h7fffff, 24'h800000, 24'h010000};
        foreach (bulges[k])
        begin
            write_reg(REG_BULGE, {8'd0, bulges[k]});
            send_point(make_point(32'sd0, 32'sd0, 32'sd0, 1'b0));
            send_point(make_point(32'sd10 << 12, -32'sd3 << 12, 32'sd1, 1'b1));
        end
        write_reg(REG_UNIT_SCALE, 32'hffffffff);
        send_point(make_point(32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
        send_point(make_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1));
        // three points with bulge set: plain segment sum
        send_point(make_point(32'sd0, 32'sd0, 32'sd0, 1'b0));
        send_point(make_point(32'sd4096, 32'sd0, 32'sd0, 1'b0));
        send_point(make_point(32'sd4096, 32'sd4096, 32'sd0, 1'b1));
    endtask

    task automatic test_random_paths();
        int   sent;
        int   plen;
        int   phase_left;
        pal_in_t p;
        logic signed [COORD_W-1:0] x, y, z;
        sent = 0;
        phase_left = 0;
        x = 0; y = 0; z = 0;
        while (sent < 1400)
        begin
            if (phase_left <= 0)
            begin
                case ($urandom_range(0, 4))
                    0: write_reg(REG_UNIT_SCALE, 32'hffffffff);
                    1: write_reg(REG_UNIT_SCALE, 32'd0);
                    2: write_reg(REG_UNIT_SCALE, UNIT_SCALE_RESET);
                    default: write_reg(REG_UNIT_SCALE, $urandom);
                endcase
                case ($urandom_range(0, 5))
                    0: write_reg(REG_BULGE, 32'd0);
                    1: write_reg(REG_BULGE, 32'h800000);
                    2: write_reg(REG_BULGE, 32'h7fffff);
                    3: write_reg(REG_BULGE, $urandom_range(1, 255));
                    default: write_reg(REG_BULGE, $urandom & 32'hffffff);
                endcase
                no_idle = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(80, 200);
            end
            case ($urandom_range(0, 9))
                0: plen = 1;
                1, 2, 3, 4: plen = 2;
                9: plen = $urandom_range(8, 20);
                default: plen = $urandom_range(3, 6);
            endcase
            for (int k = 0; k < plen; k++)
            begin
                x = rand_coord(x);
                y = rand_coord(y);
                z = rand_coord(z);
                p = make_point(x, y, z, k == plen - 1);
                send_point(p);
            end
            sent += plen;
            phase_left -= plen;
        end
    endtask

    // output side back-pressure
    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_hold <= out_hold - 1;
            out_stall <= 1'b1;
        end
        else if (!no_idle && $urandom_range(0, 9) == 0)
        begin
            out_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        pal_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (path_len_q.size() == 0)
            begin
                $error("unexpected result transaction length_m=%0h", out_data.length_m);
                errors++;
            end
            else
            begin
                want = path_len_q.pop_front();
                if (out_data.length_m !== want.length_m)
                begin
                    $error("length_m expected %0h actual %0h", want.length_m,
                           out_data.length_m);
                    errors++;
                end
                if (out_data.used_arc !== want.used_arc)
                begin
                    $error("used_arc expected %0b actual %0b", want.used_arc,
                           out_data.used_arc);
                    errors++;
                end
                if (out_data.overflowed !== want.overflowed)
                begin
                    $error("overflowed expected %0b actual %0b", want.overflowed,
                           out_data.overflowed);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        no_idle = 1'b0;
        out_hold = 0;
        out_stall = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        scale_q = UNIT_SCALE_RESET;
        bulge_q = '0;
        last_x = 0; last_y = 0; last_z = 0;
        pts_seen = 0;
        path_sum = '0;
        path_sat = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_single_point();
        test_extreme_segments();
        test_bulge_arc();
        test_random_paths();

        wait_idle();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
